// ===== sv/srr_pkg.sv =====
// Shared types, constants and the slot lookup table builder for the receiver.
`timescale 1ns / 1ps

package srr_pkg;

    // Fixed widths of the port fields.
    localparam int SEQ_BITS          = 8;
    localparam int PORT_PAYLOAD_BITS = 32;

    // Defaults for the top-level parameters.
    localparam int WINDOW_DEFAULT       = 8;
    localparam int PAYLOAD_BITS_DEFAULT = 32;

    // Widest slot index needed by the largest supported window of 64.
    localparam int SLOT_TAB_BITS = 6;

    // Result kinds.
    localparam logic RES_ACK     = 1'b0;
    localparam logic RES_DELIVER = 1'b1;

    typedef logic [SLOT_TAB_BITS-1:0] t_slot_tab [256];

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_frame;
        logic do_ack;
        logic do_read;
        logic do_deliver;
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic start_drain;
        logic more;
    } t_dp_status;

    // Sequence number to slot index, built by counting so no divider is needed.
    function automatic t_slot_tab slot_table(int unsigned w);
        t_slot_tab              tab;
        logic [SLOT_TAB_BITS-1:0] c;
        c = '0;
        for (int i = 0; i < 256; i++) begin
            tab[i] = c;
            if (int'(c) == int'(w) - 1) begin
                c = '0;
            end else begin
                c = c + 1'b1;
            end
        end
        return tab;
    endfunction

endpackage

// ===== sv/srr_ctrl.sv =====
// Controller state machine that sequences accept, acknowledge and the in-order drain.
`timescale 1ns / 1ps

module srr_ctrl import srr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_frame_valid,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_cmd,
    output logic       o_busy
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_ACK  = 4'b0010,
        S_RD   = 4'b0100,
        S_DLV  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_frame_valid) begin
                    o_cmd.load_frame = 1'b1;
                    n_state          = S_ACK;
                end
            end
            S_ACK: begin
                if (i_status.out_free) begin
                    o_cmd.do_ack = 1'b1;
                    n_state      = i_status.start_drain ? S_RD : S_IDLE;
                end
            end
            S_RD: begin
                o_cmd.do_read = 1'b1;
                n_state       = S_DLV;
            end
            S_DLV: begin
                if (i_status.out_free) begin
                    o_cmd.do_deliver = 1'b1;
                    n_state          = i_status.more ? S_RD : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== sv/srr_datapath.sv =====
// Datapath: frame capture, window test, slot valid bits, payload buffer and result register.
`timescale 1ns / 1ps

module srr_datapath import srr_pkg::*; #(
    parameter int WINDOW       = WINDOW_DEFAULT,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEFAULT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_ctrl_cmd                    i_cmd,
    output t_dp_status                   o_status,
    input  logic [SEQ_BITS-1:0]          i_frame_seq,
    input  logic [PORT_PAYLOAD_BITS-1:0] i_frame_payload,
    input  logic                         i_result_stall,
    output logic                         o_result_valid,
    output logic                         o_result_kind,
    output logic [SEQ_BITS-1:0]          o_result_seq,
    output logic                         o_accepted,
    output logic [PORT_PAYLOAD_BITS-1:0] o_result_payload,
    output logic                         o_last
);

    localparam int SLOT_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int STORE_BITS = (PAYLOAD_BITS < PORT_PAYLOAD_BITS) ?
                                PAYLOAD_BITS : PORT_PAYLOAD_BITS;
    localparam logic [SLOT_W-1:0]   LastSlot  = SLOT_W'(WINDOW - 1);
    localparam logic [SEQ_BITS-1:0] WindowLen = SEQ_BITS'(WINDOW);
    localparam logic [SEQ_BITS-1:0] MaxSeq    = '1;
    localparam t_slot_tab           SlotTab   = slot_table(WINDOW);

    logic [SEQ_BITS-1:0]          r_seq;
    logic [STORE_BITS-1:0]        r_payload;
    logic [SEQ_BITS-1:0]          r_next_exp;
    logic [SLOT_W-1:0]            r_slot_ne;
    logic [WINDOW-1:0]            r_valid;
    logic [STORE_BITS-1:0]        r_mem [WINDOW];
    logic [STORE_BITS-1:0]        r_rd_data;

    logic                         r_out_valid;
    logic                         r_kind;
    logic [SEQ_BITS-1:0]          r_rseq;
    logic                         r_acc;
    logic [PORT_PAYLOAD_BITS-1:0] r_rpayload;
    logic                         r_last;

    logic [SEQ_BITS-1:0] offset;
    logic                acc;
    logic                start_drain;
    logic [SLOT_W-1:0]   arr_slot;
    logic [SLOT_W-1:0]   nslot;
    logic                more;

    assign offset      = r_seq - r_next_exp;
    assign acc         = (offset < WindowLen);
    assign start_drain = acc && (offset == '0);
    assign arr_slot    = SlotTab[r_seq][SLOT_W-1:0];
    // Slot of the sequence number after next_expected; wraps to zero past the last slot or past 255.
    assign nslot       = ((r_next_exp == MaxSeq) || (r_slot_ne == LastSlot)) ?
                         '0 : (r_slot_ne + 1'b1);
    // The current slot is cleared by this delivery, so it never counts as the next one.
    assign more        = r_valid[nslot] && (nslot != r_slot_ne);

    assign o_status.out_free    = !r_out_valid || !i_result_stall;
    assign o_status.start_drain = start_drain;
    assign o_status.more        = more;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_frame) begin
            r_seq     <= i_frame_seq;
            r_payload <= i_frame_payload[STORE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_ack && acc) begin
            r_mem[arr_slot] <= r_payload;
        end
        if (i_cmd.do_read) begin
            r_rd_data <= r_mem[r_slot_ne];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_exp <= '0;
            r_slot_ne  <= '0;
            r_valid    <= '0;
        end else begin
            if (i_cmd.do_ack && acc) begin
                r_valid[arr_slot] <= 1'b1;
            end
            if (i_cmd.do_deliver) begin
                r_valid[r_slot_ne] <= 1'b0;
                r_next_exp         <= r_next_exp + 1'b1;
                r_slot_ne          <= nslot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.do_ack || i_cmd.do_deliver) begin
            r_out_valid <= 1'b1;
        end else if (!i_result_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_ack) begin
            r_kind     <= RES_ACK;
            r_rseq     <= r_seq;
            r_acc      <= acc;
            r_rpayload <= '0;
            r_last     <= !start_drain;
        end else if (i_cmd.do_deliver) begin
            r_kind     <= RES_DELIVER;
            r_rseq     <= r_next_exp;
            r_acc      <= 1'b1;
            r_rpayload <= PORT_PAYLOAD_BITS'(r_rd_data);
            r_last     <= !more;
        end
    end

    assign o_result_valid   = r_out_valid;
    assign o_result_kind    = r_kind;
    assign o_result_seq     = r_rseq;
    assign o_accepted       = r_acc;
    assign o_result_payload = r_rpayload;
    assign o_last           = r_last;

endmodule

// ===== sv/selective_repeat_receiver.sv =====
// Top level of the selective-repeat receiver: controller plus datapath.
`timescale 1ns / 1ps

// Receiver half of a selective-repeat sliding window. Every frame request yields an
// acknowledgment result that echoes its sequence number and tells whether the frame
// fell inside the window [next_expected, next_expected + WINDOW) modulo 256. An
// accepted frame is buffered in slot seq mod WINDOW; when it is the expected frame it
// is delivered, followed in order by every frame already buffered behind it, and the
// final result of each request carries o_last. Sequence: a request is taken in the idle
// state and its acknowledgment is loaded into the output register in the acknowledge
// state once the output side is free. Each delivered frame then takes a read of the
// payload buffer (a memory with a registered read) and a load of the result, which also
// waits while the output side stalls; at most WINDOW frames are delivered per request.
// A new request is taken as soon as the last result is in the output register, even
// while that result still waits.

module selective_repeat_receiver import srr_pkg::*; #(
    parameter int WINDOW       = WINDOW_DEFAULT,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEFAULT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_frame_valid,
    output logic                         o_frame_stall,
    input  logic [SEQ_BITS-1:0]          i_frame_seq,
    input  logic [PORT_PAYLOAD_BITS-1:0] i_frame_payload,
    output logic                         o_result_valid,
    input  logic                         i_result_stall,
    output logic                         o_result_kind,
    output logic [SEQ_BITS-1:0]          o_result_seq,
    output logic                         o_accepted,
    output logic [PORT_PAYLOAD_BITS-1:0] o_result_payload,
    output logic                         o_last
);

    t_ctrl_cmd  cmd;
    t_dp_status status;

    // The controller walks accept, acknowledge, then read and deliver per buffered frame.
    srr_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_frame_valid (i_frame_valid),
        .i_status      (status),
        .o_cmd         (cmd),
        .o_busy        (o_frame_stall)
    );

    // The datapath holds the window state, the payload buffer and the output register.
    srr_datapath #(
        .WINDOW       (WINDOW),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_frame_seq      (i_frame_seq),
        .i_frame_payload  (i_frame_payload),
        .i_result_stall   (i_result_stall),
        .o_result_valid   (o_result_valid),
        .o_result_kind    (o_result_kind),
        .o_result_seq     (o_result_seq),
        .o_accepted       (o_accepted),
        .o_result_payload (o_result_payload),
        .o_last           (o_last)
    );

endmodule
